// ===== design/imu_complementary_orientation_core_macros.svh =====
// Assertion macros for the orientation filter back end.
`ifndef IMU_COMPLEMENTARY_ORIENTATION_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_ORIENTATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICOF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("icof assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICOF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("icof assertion failed");

`endif

// ===== design/icof_pkg.sv =====
// Types, constants and helper functions for the orientation filter.
package icof_pkg;

  typedef logic signed [23:0] angle_t;
  typedef logic signed [15:0] sample_t;

  typedef enum logic {
    KIND_UPDATE    = 1'b0,
    KIND_YAW_RESET = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    sample_t    ax;
    sample_t    ay;
    sample_t    az;
    sample_t    rx;
    sample_t    ry;
    sample_t    rz;
  } item_t;

  localparam logic CFG_ALPHA  = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  localparam logic [15:0] ALPHA_RST  = 16'd64225;
  localparam logic [15:0] PERIOD_RST = 16'd2185;

  localparam int unsigned MaxSteps = 24;

  localparam logic signed [27:0] ANG_MAX = 28'sd8388607;
  localparam logic signed [27:0] ANG_MIN = -28'sd8388608;

  // atan(2^-i) in 1/65536 degree.
  function automatic logic [22:0] atan_lut(logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  function automatic angle_t sat_angle(logic signed [27:0] v);
    angle_t r;
    if (v > ANG_MAX) begin
      r = ANG_MAX[23:0];
    end else if (v < ANG_MIN) begin
      r = ANG_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== design/imu_complementary_orientation_core.sv =====
// Complementary roll/pitch/yaw filter: one IMU sample beat in, one angle beat out.
// Each sample beat yields one result beat with roll, pitch and yaw in 1/64 degree after
// the update. An update beat occupies the back end through squaring, a bit-serial
// square root and one CORDIC iteration per step in two tilt units running side by side,
// then blending on a shared multiplier. A yaw-reset beat skips that work and clears yaw.
// A two-beat queue in front keeps accepting samples while the back end works, until it
// is full, and the result register holds the last beat until it is taken. Configuration
// writes are always ready and should be issued only while the block is idle.
module imu_complementary_orientation_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  icof_pkg::sample_t accel_x_i,
  input  icof_pkg::sample_t accel_y_i,
  input  icof_pkg::sample_t accel_z_i,
  input  icof_pkg::sample_t rate_x_i,
  input  icof_pkg::sample_t rate_y_i,
  input  icof_pkg::sample_t rate_z_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output icof_pkg::angle_t roll_out_o,
  output icof_pkg::angle_t pitch_out_o,
  output icof_pkg::angle_t yaw_out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [15:0]      cfg_data_i
);
  import icof_pkg::*;

  logic [15:0] alpha_q, period_q;
  logic        q_valid, pop;
  item_t       item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALPHA:  alpha_q  <= cfg_data_i;
        CFG_PERIOD: period_q <= cfg_data_i;
        default:    alpha_q  <= alpha_q;
      endcase
    end
  end

  icof_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .rate_x_i   (rate_x_i),
    .rate_y_i   (rate_y_i),
    .rate_z_i   (rate_z_i),
    .q_valid_o  (q_valid),
    .item_o     (item),
    .pop_i      (pop)
  );

  icof_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (item),
    .pop_o       (pop),
    .alpha_i     (alpha_q),
    .period_i    (period_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .roll_out_o  (roll_out_o),
    .pitch_out_o (pitch_out_o),
    .yaw_out_o   (yaw_out_o)
  );

endmodule

// ===== design/icof_front.sv =====
// Front end: accepts sample beats, classifies them and queues them for the back end.
module icof_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  icof_pkg::sample_t accel_x_i,
  input  icof_pkg::sample_t accel_y_i,
  input  icof_pkg::sample_t accel_z_i,
  input  icof_pkg::sample_t rate_x_i,
  input  icof_pkg::sample_t rate_y_i,
  input  icof_pkg::sample_t rate_z_i,
  output logic             q_valid_o,
  output icof_pkg::item_t  item_o,
  input  logic             pop_i
);
  import icof_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.kind = mode_i ? KIND_YAW_RESET : KIND_UPDATE;
    item_in.ax   = accel_x_i;
    item_in.ay   = accel_y_i;
    item_in.az   = accel_z_i;
    item_in.rx   = rate_x_i;
    item_in.ry   = rate_y_i;
    item_in.rz   = rate_z_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign item_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/icof_tilt.sv =====
// Tilt unit: bit-serial square root followed by an iterative vectoring CORDIC.
module icof_tilt #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [16:0]    num_i,
  input  icof_pkg::sample_t     p_i,
  input  icof_pkg::sample_t     q_i,
  output logic                  done_o,
  output icof_pkg::angle_t      angle_o
);
  import icof_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam logic [4:0]  LastStep = 5'(Steps - 1);

  typedef enum logic [2:0] {T_IDLE, T_SQ0, T_SQ1, T_SQ2, T_ROOT, T_ROT, T_FIN} tstate_e;

  tstate_e            state_q;
  sample_t            p_q, q_q;
  logic signed [16:0] num_q;
  logic signed [31:0] prod_q;
  logic [31:0]        sum_q;
  logic [47:0]        v_q, r_q, b_q;
  logic signed [27:0] x_q, y_q;
  logic signed [25:0] z_q;
  logic [4:0]         i_q;
  logic               zero_q;
  logic               done_q;
  angle_t             angle_q;

  logic [31:0]        sq_sum;
  logic [47:0]        rb, v_d, r_d;
  logic signed [27:0] xs, ys;
  logic signed [25:0] at, zr;

  assign sq_sum = sum_q + unsigned'(prod_q);
  assign rb     = r_q + b_q;

  always_comb begin
    if (v_q >= rb) begin
      v_d = v_q - rb;
      r_d = (r_q >> 1) + b_q;
    end else begin
      v_d = v_q;
      r_d = r_q >> 1;
    end
  end

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = {3'b000, atan_lut(i_q)};
  assign zr = (z_q + 26'sd512) >>> 10;

  assign done_o  = done_q;
  assign angle_o = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      p_q     <= '0;
      q_q     <= '0;
      num_q   <= '0;
      prod_q  <= '0;
      sum_q   <= '0;
      v_q     <= '0;
      r_q     <= '0;
      b_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      i_q     <= '0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
      angle_q <= '0;
    end else begin
      done_q <= (state_q == T_FIN);
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            p_q     <= p_i;
            q_q     <= q_i;
            num_q   <= num_i;
            state_q <= T_SQ0;
          end
        end
        T_SQ0: begin
          prod_q  <= p_q * p_q;
          state_q <= T_SQ1;
        end
        T_SQ1: begin
          sum_q   <= unsigned'(prod_q);
          prod_q  <= q_q * q_q;
          state_q <= T_SQ2;
        end
        T_SQ2: begin
          v_q     <= {sq_sum, 16'h0000};
          r_q     <= '0;
          b_q     <= 48'd1 << 46;
          zero_q  <= (sq_sum == 32'd0) && (num_q == 17'sd0);
          state_q <= T_ROOT;
        end
        T_ROOT: begin
          v_q <= v_d;
          r_q <= r_d;
          b_q <= b_q >> 2;
          if (b_q[0]) begin
            x_q <= {4'b0000, r_d[23:0]};
            y_q <= {{3{num_q[16]}}, num_q, 8'h00};
            z_q <= '0;
            i_q <= '0;
            // Both arguments zero: the angle is defined as zero.
            state_q <= zero_q ? T_FIN : T_ROT;
          end
        end
        T_ROT: begin
          if (y_q > 28'sd0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end
          i_q <= i_q + 5'd1;
          if (i_q == LastStep) begin
            state_q <= T_FIN;
          end
        end
        T_FIN: begin
          angle_q <= zr[23:0];
          state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== design/icof_back.sv =====
// Back end: runs the tilt units, gyro integration and blend, and holds the result beat.
module icof_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  icof_pkg::item_t  item_i,
  output logic             pop_o,
  input  logic [15:0]      alpha_i,
  input  logic [15:0]      period_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output icof_pkg::angle_t roll_out_o,
  output icof_pkg::angle_t pitch_out_o,
  output icof_pkg::angle_t yaw_out_o
);
  import icof_pkg::*;
  `include "imu_complementary_orientation_core_macros.svh"

  typedef enum logic [3:0] {
    B_IDLE, B_START, B_G0, B_G1, B_G2, B_G3, B_WAIT,
    B_B0, B_B1, B_B2, B_B3, B_B4, B_FIN
  } bstate_e;

  bstate_e            state_q;
  item_t              item_q;
  logic signed [43:0] mul_q, t_q;
  logic signed [19:0] dr_q, dp_q, dy_q;
  angle_t             acc_r_q, acc_p_q;
  logic               r_ok_q, p_ok_q;
  angle_t             roll_q, pitch_q, yaw_q;
  logic               out_valid_q;
  angle_t             roll_out_q, pitch_out_q, yaw_out_q;

  logic               tilt_start;
  logic               roll_done, pitch_done;
  angle_t             roll_acc, pitch_acc;
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [17:0] a_ext, oma_ext, dt_ext;
  logic signed [43:0] g_rnd, s_rnd;
  logic signed [19:0] d_new;
  angle_t             blend_new, yaw_new;
  logic               out_load;

  assign pop_o      = (state_q == B_IDLE) && q_valid_i;
  assign tilt_start = (state_q == B_START) && (item_q.kind == KIND_UPDATE);
  assign out_load   = (state_q == B_FIN) && (!out_valid_q || !out_stall_i);

  icof_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tilt_start),
    .num_i   ({item_q.ay[15], item_q.ay}),
    .p_i     (item_q.ax),
    .q_i     (item_q.az),
    .done_o  (roll_done),
    .angle_o (roll_acc)
  );

  icof_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tilt_start),
    .num_i   (17'sd0 - {item_q.ax[15], item_q.ax}),
    .p_i     (item_q.ay),
    .q_i     (item_q.az),
    .done_o  (pitch_done),
    .angle_o (pitch_acc)
  );

  assign a_ext   = {2'b00, alpha_i};
  assign oma_ext = {1'b0, 17'(17'h10000 - {1'b0, alpha_i})};
  assign dt_ext  = {2'b00, period_i};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      B_G0: begin
        mul_a = {{10{item_q.rx[15]}}, item_q.rx};
        mul_b = dt_ext;
      end
      B_G1: begin
        mul_a = {{10{item_q.ry[15]}}, item_q.ry};
        mul_b = dt_ext;
      end
      B_G2: begin
        mul_a = {{10{item_q.rz[15]}}, item_q.rz};
        mul_b = dt_ext;
      end
      B_B0: begin
        mul_a = {{2{roll_q[23]}}, roll_q} + {{6{dr_q[19]}}, dr_q};
        mul_b = a_ext;
      end
      B_B1: begin
        mul_a = {{2{acc_r_q[23]}}, acc_r_q};
        mul_b = oma_ext;
      end
      B_B2: begin
        mul_a = {{2{pitch_q[23]}}, pitch_q} + {{6{dp_q[19]}}, dp_q};
        mul_b = a_ext;
      end
      B_B3: begin
        mul_a = {{2{acc_p_q[23]}}, acc_p_q};
        mul_b = oma_ext;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Gyro increment rounds half up at bit 14; blend rounds half up at bit 16.
  assign g_rnd     = mul_q + 44'sd8192;
  assign d_new     = g_rnd[33:14];
  assign s_rnd     = t_q + mul_q + 44'sd32768;
  assign blend_new = sat_angle(s_rnd[43:16]);
  assign yaw_new   = sat_angle({{4{yaw_q[23]}}, yaw_q} + {{8{dy_q[19]}}, dy_q});

  assign out_valid_o = out_valid_q;
  assign roll_out_o  = roll_out_q;
  assign pitch_out_o = pitch_out_q;
  assign yaw_out_o   = yaw_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      item_q      <= '0;
      mul_q       <= '0;
      t_q         <= '0;
      dr_q        <= '0;
      dp_q        <= '0;
      dy_q        <= '0;
      acc_r_q     <= '0;
      acc_p_q     <= '0;
      r_ok_q      <= 1'b0;
      p_ok_q      <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
      roll_out_q  <= '0;
      pitch_out_q <= '0;
      yaw_out_q   <= '0;
    end else begin
      mul_q <= mul_a * mul_b;
      if (roll_done) begin
        acc_r_q <= roll_acc;
        r_ok_q  <= 1'b1;
      end
      if (pitch_done) begin
        acc_p_q <= pitch_acc;
        p_ok_q  <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            item_q  <= item_i;
            state_q <= B_START;
          end
        end
        B_START: begin
          if (item_q.kind == KIND_YAW_RESET) begin
            yaw_q   <= '0;
            state_q <= B_FIN;
          end else begin
            r_ok_q  <= 1'b0;
            p_ok_q  <= 1'b0;
            state_q <= B_G0;
          end
        end
        B_G0: state_q <= B_G1;
        B_G1: begin
          dr_q    <= d_new;
          state_q <= B_G2;
        end
        B_G2: begin
          dp_q    <= d_new;
          state_q <= B_G3;
        end
        B_G3: begin
          dy_q    <= d_new;
          state_q <= B_WAIT;
        end
        B_WAIT: begin
          if (r_ok_q && p_ok_q) begin
            state_q <= B_B0;
          end
        end
        B_B0: state_q <= B_B1;
        B_B1: begin
          t_q     <= mul_q;
          state_q <= B_B2;
        end
        B_B2: begin
          roll_q  <= blend_new;
          state_q <= B_B3;
        end
        B_B3: begin
          t_q     <= mul_q;
          state_q <= B_B4;
        end
        B_B4: begin
          pitch_q <= blend_new;
          yaw_q   <= yaw_new;
          state_q <= B_FIN;
        end
        B_FIN: begin
          if (out_load) begin
            roll_out_q  <= roll_q;
            pitch_out_q <= pitch_q;
            yaw_out_q   <= yaw_q;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `ICOF_ASSERT_IMP(a_tilt_pair, clk_i, rst_ni, roll_done, pitch_done)
  `ICOF_ASSERT_IMP(a_load_free, clk_i, rst_ni, out_load, !out_valid_q || !out_stall_i)
  `ICOF_ASSERT_NXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_q)
  `ICOF_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, pop_o, !tilt_start && !out_load)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the complementary roll/pitch/yaw orientation filter.
`timescale 1ns / 100ps

module testbench;
  import icof_pkg::*;

  typedef struct {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } attitude_t;

  localparam int unsigned NumSteps = 16;
  localparam longint AtanDeg[16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  sample_t     ax = '0, ay = '0, az = '0, rx = '0, ry = '0, rz = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  angle_t      roll_o, pitch_o, yaw_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_ALPHA;
  logic [15:0] cfg_data = '0;

  imu_complementary_orientation_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .accel_x_i(ax), .accel_y_i(ay), .accel_z_i(az),
    .rate_x_i(rx), .rate_y_i(ry), .rate_z_i(rz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .roll_out_o(roll_o), .pitch_out_o(pitch_o), .yaw_out_o(yaw_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state and its copy of the registers.
  longint      roll_q, pitch_q, yaw_q;
  logic [15:0] alpha_q = ALPHA_RST;
  logic [15:0] period_q = PERIOD_RST;

  item_t       sample_queue[$];
  attitude_t   attitude_queue[$];
  item_t       cur_item;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          no_idle = 1'b0;
  int          mismatches = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_angle(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Tilt angle atan2(num, sqrt(p^2 + q^2)) in 1/64 degree.
  function automatic longint tilt_angle(longint num, longint p, longint q);
    longint unsigned v, r, b;
    longint x, y, z, xs, ys;
    v = longint'(p * p + q * q) << 16;
    r = 0;
    b = 64'd1 << 46;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    x = longint'(r);
    y = num * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < NumSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanDeg[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanDeg[i];
      end
    end
    return (z + 512) >>> 10;
  endfunction

  function automatic longint gyro_delta(sample_t rate);
    return (longint'(rate) * longint'(period_q) + 8192) >>> 14;
  endfunction

  function automatic longint blend_angle(longint prev, longint d, longint acc);
    longint a;
    a = longint'(alpha_q);
    return clamp_angle((a * (prev + d) + (65536 - a) * acc + 32768) >>> 16);
  endfunction

  function automatic attitude_t predict_attitude(item_t it);
    attitude_t r;
    longint acc_roll, acc_pitch;
    if (it.kind == KIND_YAW_RESET) begin
      yaw_q = 0;
    end else begin
      acc_roll = tilt_angle(longint'(it.ay), longint'(it.ax), longint'(it.az));
      acc_pitch = tilt_angle(-longint'(it.ax), longint'(it.ay), longint'(it.az));
      roll_q = blend_angle(roll_q, gyro_delta(it.rx), acc_roll);
      pitch_q = blend_angle(pitch_q, gyro_delta(it.ry), acc_pitch);
      yaw_q = clamp_angle(yaw_q + gyro_delta(it.rz));
    end
    r.roll = angle_t'(roll_q);
    r.pitch = angle_t'(pitch_q);
    r.yaw = angle_t'(yaw_q);
    return r;
  endfunction

  // Sample driver.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        attitude_queue.push_back(predict_attitude(cur_item));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          cur_item = sample_queue.pop_front();
          mode <= cur_item.kind;
          ax <= cur_item.ax;
          ay <= cur_item.ay;
          az <= cur_item.az;
          rx <= cur_item.rx;
          ry <= cur_item.ry;
          rz <= cur_item.rz;
          in_valid <= 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk or negedge rst_n) begin
    attitude_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (attitude_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected beat: roll %0d pitch %0d yaw %0d", roll_o, pitch_o, yaw_o);
        end else begin
          e = attitude_queue.pop_front();
          if (e.roll !== roll_o || e.pitch !== pitch_o || e.yaw !== yaw_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Wrong beat: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       e.roll, e.pitch, e.yaw, roll_o, pitch_o, yaw_o);
          end
        end
        recv_gap = no_idle ? 0 : $urandom_range(0, 13);
      end else if (out_valid && recv_gap > 0) begin
        recv_gap--;
      end
      out_stall <= (recv_gap > 0);
    end
  end

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ALPHA) alpha_q = data;
    else period_q = data;
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender until every queued sample has been answered.
  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_valid || attitude_queue.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic item_t make_item(item_kind_e k, int a_x, int a_y, int a_z,
                                      int r_x, int r_y, int r_z);
    item_t it;
    it.kind = k;
    it.ax = sample_t'(a_x);
    it.ay = sample_t'(a_y);
    it.az = sample_t'(a_z);
    it.rx = sample_t'(r_x);
    it.ry = sample_t'(r_y);
    it.rz = sample_t'(r_z);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel;
    it = make_item(KIND_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      it.kind = KIND_YAW_RESET;
    end else if (sel < 50) begin
      // Plausible readings: around one g and modest rates.
      it.ax = sample_t'(int'($urandom_range(0, 2400)) - 1200);
      it.ay = sample_t'(int'($urandom_range(0, 2400)) - 1200);
      it.az = sample_t'(int'($urandom_range(0, 2400)) - 1200);
      it.rx = sample_t'(int'($urandom_range(0, 8000)) - 4000);
      it.ry = sample_t'(int'($urandom_range(0, 8000)) - 4000);
      it.rz = sample_t'(int'($urandom_range(0, 8000)) - 4000);
    end else if (sel < 53) begin
      it.ax = '0;
      it.ay = '0;
      it.az = '0;
    end
    return it;
  endfunction

  task automatic run_phase(logic [15:0] alpha, logic [15:0] period, int count);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_PERIOD, period);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sample_queue.push_back(random_item());
    end
    wait_drained();
  endtask

  initial begin
    roll_q = 0;
    pitch_q = 0;
    yaw_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Directed beats: field extremes, zero acceleration, yaw reset with junk fields.
    sample_queue.push_back(make_item(KIND_UPDATE, 0, 0, 0, 0, 0, 0));
    sample_queue.push_back(make_item(KIND_UPDATE, 0, 0, 1000, 0, 0, 0));
    sample_queue.push_back(make_item(KIND_UPDATE, 32767, 32767, 32767, 32767, 32767, 32767));
    sample_queue.push_back(make_item(KIND_UPDATE, -32768, -32768, -32768,
                                     -32768, -32768, -32768));
    sample_queue.push_back(make_item(KIND_UPDATE, -32768, 32767, 0, 32767, -32768, 1));
    sample_queue.push_back(make_item(KIND_UPDATE, 32767, -32768, 0, -1, 1, -32768));
    sample_queue.push_back(make_item(KIND_UPDATE, 0, 1000, 0, 16, -16, 100));
    sample_queue.push_back(make_item(KIND_UPDATE, 1000, 0, 0, 0, 0, 0));
    sample_queue.push_back(make_item(KIND_UPDATE, 0, 0, -1000, -3, 3, -100));
    sample_queue.push_back(make_item(KIND_UPDATE, 0, -1, 0, 0, 0, 0));
    sample_queue.push_back(make_item(KIND_YAW_RESET, 0, 0, 0, 0, 0, 0));
    sample_queue.push_back(make_item(KIND_UPDATE, 5, 7, 0, 0, 0, 32767));
    sample_queue.push_back(make_item(KIND_YAW_RESET, -1, 32767, -32768, -1, -1, -1));
    sample_queue.push_back(make_item(KIND_UPDATE, 0, 0, 0, 1, 1, 1));
    wait_drained();
    run_phase(ALPHA_RST, PERIOD_RST, 250);
    run_phase(16'd0, PERIOD_RST, 150);
    // Maximum gyro weight and the longest step let the angles reach saturation.
    run_phase(16'd65535, 16'd65535, 250);
    run_phase(16'd32768, 16'd1, 150);
    run_phase(ALPHA_RST, 16'd0, 120);
    run_phase(16'd1000, 16'd40000, 320);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== imu_complementary_orientation_core.f =====
+incdir+design
design/icof_pkg.sv
design/icof_front.sv
design/icof_tilt.sv
design/icof_back.sv
design/imu_complementary_orientation_core.sv
verif/testbench.sv
